// ===== rtl/sois_pkg.sv =====
// Shared types and constants for the second-order IIR section.
// Holds the coefficient set, the register index codes and their reset values.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package sois_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef logic signed [DATA_W-1:0] sois_word_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INPUT_GAIN      = 3'd0,
      REG_FEEDBACK_COEF_1 = 3'd1,
      REG_FEEDBACK_COEF_2 = 3'd2,
      REG_FORWARD_COEF_1  = 3'd3,
      REG_FORWARD_COEF_2  = 3'd4
   } sois_reg_index_type;

   typedef struct packed {
      sois_word_type input_gain;
      sois_word_type feedback_coef_1;
      sois_word_type feedback_coef_2;
      sois_word_type forward_coef_1;
      sois_word_type forward_coef_2;
   } sois_coef_type;

   localparam sois_word_type INPUT_GAIN_RESET      = 32'sd29766316;
   localparam sois_word_type FEEDBACK_COEF_1_RESET = -32'sd2138383679;
   localparam sois_word_type FEEDBACK_COEF_2_RESET = 32'sd1064691815;
   localparam sois_word_type FORWARD_COEF_1_RESET  = 32'sd0;
   localparam sois_word_type FORWARD_COEF_2_RESET  = -32'sd1073741824;

endpackage

`default_nettype wire

// ===== rtl/sois_coef_regs.sv =====
// Coefficient registers of the IIR section, written through the plain write port.
// Depends on sois_pkg for the coefficient struct, index codes and reset values.
`default_nettype none

module sois_coef_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [sois_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sois_pkg::DATA_W-1:0]        csr_wdata,
   output sois_pkg::sois_coef_type                 coef
);
   import sois_pkg::*;

   sois_coef_type coef_ff;
   sois_coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (sois_reg_index_type'(csr_index))
            REG_INPUT_GAIN:      coef_in.input_gain      = csr_wdata;
            REG_FEEDBACK_COEF_1: coef_in.feedback_coef_1 = csr_wdata;
            REG_FEEDBACK_COEF_2: coef_in.feedback_coef_2 = csr_wdata;
            REG_FORWARD_COEF_1:  coef_in.forward_coef_1  = csr_wdata;
            REG_FORWARD_COEF_2:  coef_in.forward_coef_2  = csr_wdata;
            default:             coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.input_gain      <= INPUT_GAIN_RESET;
         coef_ff.feedback_coef_1 <= FEEDBACK_COEF_1_RESET;
         coef_ff.feedback_coef_2 <= FEEDBACK_COEF_2_RESET;
         coef_ff.forward_coef_1  <= FORWARD_COEF_1_RESET;
         coef_ff.forward_coef_2  <= FORWARD_COEF_2_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

// ===== rtl/sois_datapath.sv =====
// Direct form II arithmetic of the IIR section and its two delay words.
// Five Q30 by Q20 products in parallel feed the feedback and forward sums.
// Depends on sois_pkg for the coefficient struct and word width.
`default_nettype none

module sois_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [sois_pkg::DATA_W-1:0]   sample_in,
   input  sois_pkg::sois_coef_type            coef,
   output logic [sois_pkg::DATA_W-1:0]        sample_out
);
   import sois_pkg::*;

   logic [DATA_W-1:0] delay_one_ff;
   logic [DATA_W-1:0] delay_one_in;
   logic [DATA_W-1:0] delay_two_ff;
   logic [DATA_W-1:0] delay_two_in;
   logic [DATA_W-1:0] gain_term;
   logic [DATA_W-1:0] fb1_term;
   logic [DATA_W-1:0] fb2_term;
   logic [DATA_W-1:0] fw1_term;
   logic [DATA_W-1:0] fw2_term;
   logic [DATA_W-1:0] state_word;

   // The product is shifted right arithmetically by 30 and its low word kept.
   function automatic logic [DATA_W-1:0] q30_mul(input logic [DATA_W-1:0] c,
                                                 input logic [DATA_W-1:0] w);
      logic signed [2*DATA_W-1:0] p;
      p = $signed(c) * $signed(w);
      return p[DATA_W+29:30];
   endfunction

   assign gain_term = q30_mul(coef.input_gain, sample_in);
   assign fb1_term  = q30_mul(coef.feedback_coef_1, delay_one_ff);
   assign fb2_term  = q30_mul(coef.feedback_coef_2, delay_two_ff);
   assign fw1_term  = q30_mul(coef.forward_coef_1, delay_one_ff);
   assign fw2_term  = q30_mul(coef.forward_coef_2, delay_two_ff);

   assign state_word = gain_term - fb1_term - fb2_term;
   assign sample_out = state_word + fw1_term + fw2_term;

   assign delay_one_in = step ? state_word : delay_one_ff;
   assign delay_two_in = step ? delay_one_ff : delay_two_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
      end
   end

   a_shift_delays : assert property (@(posedge clock) disable iff (reset)
      step |=> (delay_two_ff == $past(delay_one_ff)))
      else $error("second delay word did not take the first on a step");

   a_hold_delays : assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(delay_one_ff) && $stable(delay_two_ff)))
      else $error("delay words changed without a step");

endmodule

`default_nettype wire

// ===== rtl/second_order_iir_section.sv =====
// Top level of the second-order IIR section: request register, datapath, response register.
// Depends on sois_pkg, sois_coef_regs and sois_datapath.
//
// The section filters one signed Q20 sample per clock cycle unless rsp_tready holds it back;
// an accepted request goes through these steps: the sample is captured in an input register, the
// recursion through the two delay words (five 32 by 32 multipliers in parallel feeding the
// feedback and forward sums) runs on it there, and the result lands in a response
// register. A new request is taken while a finished response still waits, so the pipeline holds
// at most two samples. Coefficients come out of reset as the first filter section and may be
// rewritten through the csr port while the section is idle; the delay words are cleared by reset
// only.
`default_nettype none

module second_order_iir_section (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [sois_pkg::DATA_W-1:0]        req_tdata,   // [31:0] sample_in
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [sois_pkg::DATA_W-1:0]             rsp_tdata,   // [31:0] sample_out
   input  wire logic                               csr_wr_en,
   input  wire logic [sois_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sois_pkg::DATA_W-1:0]        csr_wdata
);
   import sois_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [DATA_W-1:0] in_data_ff;
   logic [DATA_W-1:0] in_data_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [DATA_W-1:0] out_data_ff;
   logic [DATA_W-1:0] out_data_in;
   logic              advance;
   logic              req_take;
   logic [DATA_W-1:0] result;
   sois_coef_type     coef;

   sois_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   sois_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .sample_in  (in_data_ff),
      .coef       (coef),
      .sample_out (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign in_data_in   = req_take ? req_tdata : in_data_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign out_data_in  = advance ? result : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("request refused while the input register is empty");

   a_advance_fills_output : assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff && out_data_ff == $past(result)))
      else $error("advanced sample did not reach the response register");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("pending response would be overwritten");

   a_request_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled request lost from the input register");

endmodule

`default_nettype wire

// ===== bench/second_order_iir_section_tb.sv =====
// Self-checking testbench for the second-order IIR section, with its own bit-exact model
// of the recursion and a stream checker. Depends on sois_pkg and second_order_iir_section.
`timescale 1ns / 100ps

module second_order_iir_section_tb;
   import sois_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] FIRST_UNMAPPED_INDEX = CSR_INDEX_W'(REG_FORWARD_COEF_2 + 1);
   localparam int unsigned            IDLE_PERCENT         = 32;
   localparam int unsigned            Q20_ONE              = 1 << 20;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [DATA_W-1:0]       csr_wdata   = '0;

   sois_word_type           gain_coef;
   sois_word_type           fb_coef_1;
   sois_word_type           fb_coef_2;
   sois_word_type           fw_coef_1;
   sois_word_type           fw_coef_2;
   sois_word_type           delay_1;
   sois_word_type           delay_2;

   logic [DATA_W-1:0]       filtered_due[$];
   int unsigned             mismatch_count = 0;
   bit                      no_idle        = 1'b0;

   second_order_iir_section u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] sample_out
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL second_order_iir_section");
      $finish;
   end

   // Q30 by Q20 product: bits 61 to 30 are the arithmetic shift by 30, truncated to a word.
   function automatic sois_word_type q30_scale(input sois_word_type coef,
                                               input sois_word_type word);
      logic signed [63:0] prod;
      prod = coef * word;
      return prod[61:30];
   endfunction

   function automatic sois_word_type iir_step(input sois_word_type x);
      sois_word_type w;
      sois_word_type y;
      w = q30_scale(gain_coef, x) - q30_scale(fb_coef_1, delay_1) - q30_scale(fb_coef_2, delay_2);
      y = w + q30_scale(fw_coef_1, delay_1) + q30_scale(fw_coef_2, delay_2);
      delay_2 = delay_1;
      delay_1 = w;
      return y;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: mismatch, %s: got %h, wanted %h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_due.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_tdata, '0);
         end else begin
            want = filtered_due.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch("sample_out", rsp_tdata, want);
            end
         end
      end
   end

   task automatic send_sample(input logic [DATA_W-1:0] x);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      filtered_due.push_back(iir_step(x));
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_INPUT_GAIN:      gain_coef = val;
         REG_FEEDBACK_COEF_1: fb_coef_1 = val;
         REG_FEEDBACK_COEF_2: fb_coef_2 = val;
         REG_FORWARD_COEF_1:  fw_coef_1 = val;
         REG_FORWARD_COEF_2:  fw_coef_2 = val;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_coefs(input logic [DATA_W-1:0] val);
      for (int r = REG_INPUT_GAIN; r <= REG_FORWARD_COEF_2; r++) begin
         csr_write(CSR_INDEX_W'(r), val);
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 8 * Q20_ONE) - 4 * Q20_ONE;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_coef();
      if ($urandom_range(1)) begin
         return $urandom;
      end
      // Mostly within plus or minus one in Q30, as a real section would be.
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   task automatic test_reset_section();
      send_sample(32'h0000_0000);
      send_sample(Q20_ONE);
      send_sample(32'h0000_0000);
      send_sample(32'h0000_0000);
      send_sample(-Q20_ONE);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA);
      send_sample(32'h0000_0001);
   endtask

   task automatic test_extreme_coefs();
      drain_pipeline();
      write_all_coefs(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0000);
      drain_pipeline();
      write_all_coefs(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      drain_pipeline();
      // Writes to indexes past the last register must leave every coefficient alone.
      for (int i = FIRST_UNMAPPED_INDEX; i < (1 << CSR_INDEX_W); i++) begin
         csr_write(CSR_INDEX_W'(i), $urandom);
      end
      send_sample(Q20_ONE);
      send_sample($urandom);
   endtask

   task automatic test_random_sections();
      for (int phase = 0; phase < 6; phase++) begin
         drain_pipeline();
         for (int r = REG_INPUT_GAIN; r <= REG_FORWARD_COEF_2; r++) begin
            csr_write(CSR_INDEX_W'(r), pick_coef());
         end
         repeat (80) send_sample(pick_sample());
      end
   endtask

   task automatic test_back_to_back();
      drain_pipeline();
      csr_write(REG_INPUT_GAIN, FORWARD_COEF_2_RESET);
      csr_write(REG_FORWARD_COEF_1, pick_coef());
      no_idle = 1'b1;
      repeat (100) send_sample(pick_sample());
      no_idle = 1'b0;
   endtask

   initial begin
      gain_coef = INPUT_GAIN_RESET;
      fb_coef_1 = FEEDBACK_COEF_1_RESET;
      fb_coef_2 = FEEDBACK_COEF_2_RESET;
      fw_coef_1 = FORWARD_COEF_1_RESET;
      fw_coef_2 = FORWARD_COEF_2_RESET;
      delay_1   = '0;
      delay_2   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_section();
      test_extreme_coefs();
      test_random_sections();
      test_back_to_back();

      drain_pipeline();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS second_order_iir_section");
      end else begin
         $display("FAIL second_order_iir_section");
      end
      $finish;
   end

endmodule
